// ===== rtl/sbx_pkg.sv =====
package sbx_pkg;

    // Field and register widths
    localparam int MAX_WINDOW     = 16;
    localparam int BX_BITS        = 12;
    localparam int COUNT_BITS     = 8;
    localparam int WHEEL_BITS     = 5;
    localparam int LEN_BITS       = 5;
    localparam int MIN_BITS       = 12;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;

    // Derived window widths
    localparam int WIN_BITS   = $clog2(MAX_WINDOW + 1);
    localparam int LCMP_BITS  = (LEN_BITS > WIN_BITS) ? LEN_BITS : WIN_BITS;
    localparam int NCMP_BITS  = (BX_BITS > WIN_BITS) ? BX_BITS : WIN_BITS;
    localparam int GROUP_SIZE = 4;
    localparam int NUM_GROUPS = (MAX_WINDOW + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GSUM_BITS  = COUNT_BITS + $clog2(GROUP_SIZE + 1);
    localparam int SUM_BITS   = COUNT_BITS + $clog2(MAX_WINDOW + 1);
    localparam int CMP_BITS   = (SUM_BITS > MIN_BITS) ? SUM_BITS : MIN_BITS;

    // Job queue between front and back
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);
    localparam int OCC_BITS   = $clog2(Q_DEPTH + 3);

    // Wheel pattern: mask with one empty boundary bit either side
    localparam int                      WHEEL_PAT_BITS = 7;
    localparam logic [WHEEL_PAT_BITS-1:0] WHEEL_INNER  = 7'b0111110;
    localparam int                      WHEEL_OFFSET   = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WINDOW_LENGTH = 2'd0,
        CFG_MIN_STUBS     = 2'd1,
        CFG_MODE          = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [LEN_BITS-1:0] window_length;
        logic [MIN_BITS-1:0] min_stubs;
        logic                mode;
    } cfg_t;

    // Run of crossings to emit, first to last inclusive
    typedef struct packed {
        logic [BX_BITS-1:0] first_bx;
        logic [BX_BITS-1:0] last_bx;
    } job_t;

    // True when two crossings hold wheels at most one apart
    function automatic logic wheels_close(input logic [WHEEL_BITS-1:0] a,
                                          input logic [WHEEL_BITS-1:0] b);
        logic [WHEEL_PAT_BITS-1:0] pa;
        logic [WHEEL_PAT_BITS-1:0] pb;
        pa = WHEEL_PAT_BITS'(a) << (WHEEL_OFFSET - 2);
        pb = WHEEL_PAT_BITS'(b) << (WHEEL_OFFSET - 2);
        return |(pa & ((pb << 1) | pb | (pb >> 1)) & WHEEL_INNER);
    endfunction

endpackage

// ===== rtl/sbx_fifo.sv =====
module sbx_fifo (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  sbx_pkg::job_t                   push_job,
    input  logic                            pop,
    output sbx_pkg::job_t                   head,
    output logic [sbx_pkg::Q_CNT_BITS-1:0]  count
);
    import sbx_pkg::*;

    job_t                  mem_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg;
    logic [Q_PTR_BITS-1:0] wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg;
    logic [Q_PTR_BITS-1:0] rd_ptr_next;
    logic [Q_CNT_BITS-1:0] count_reg;
    logic [Q_CNT_BITS-1:0] count_next;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < Q_CNT_BITS'(Q_DEPTH)))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("job queue read while empty");

endmodule

// ===== rtl/sbx_front.sv =====
module sbx_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sbx_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              orbit_start,
    input  logic [sbx_pkg::BX_BITS-1:0]       bx_number,
    input  logic [sbx_pkg::COUNT_BITS-1:0]    stub_count,
    input  logic [sbx_pkg::WHEEL_BITS-1:0]    wheel_mask,
    input  logic [sbx_pkg::Q_CNT_BITS-1:0]    q_count,
    output logic                              push,
    output sbx_pkg::job_t                     push_job
);
    import sbx_pkg::*;

    logic                  accept;
    logic [OCC_BITS-1:0]   occupancy;
    logic [WIN_BITS-1:0]   len_eff;
    logic [WIN_BITS-1:0]   n_in;

    // Crossing history, newest first
    logic [COUNT_BITS-1:0] count_hist_reg [MAX_WINDOW];
    logic [WHEEL_BITS-1:0] wheel_hist_reg [MAX_WINDOW];

    // Group sum and wheel stage
    logic                  s1_valid_reg;
    logic                  s1_clear_reg;
    logic [BX_BITS-1:0]    s1_bx_reg;
    logic [WIN_BITS-1:0]   s1_n_reg;
    logic [GSUM_BITS-1:0]  gsum_next [NUM_GROUPS];
    logic                  close_next;

    // Decision stage
    logic                  s2_valid_reg;
    logic                  s2_clear_reg;
    logic [BX_BITS-1:0]    s2_bx_reg;
    logic [WIN_BITS-1:0]   s2_n_reg;
    logic [GSUM_BITS-1:0]  s2_gsum_reg [NUM_GROUPS];
    logic                  s2_close_reg;

    // Record of emitted crossings in this orbit
    logic [BX_BITS-1:0]    highest_reg;
    logic [BX_BITS-1:0]    highest_next;
    logic                  any_emitted_reg;
    logic                  any_emitted_next;

    logic [SUM_BITS-1:0]   sum;
    logic                  pass;
    logic                  any_eff;
    logic [BX_BITS-1:0]    lo;

    // Hold input while pipeline and queue could overflow
    assign occupancy = OCC_BITS'(q_count) + OCC_BITS'(s1_valid_reg)
                     + OCC_BITS'(s2_valid_reg);
    assign in_ready  = (occupancy < OCC_BITS'(Q_DEPTH));
    assign accept    = in_valid && in_ready;

    // Clamp window length and trim at start of orbit
    always_comb
    begin
        if (cfg.window_length == '0)
        begin
            len_eff = WIN_BITS'(1);
        end
        else if (LCMP_BITS'(cfg.window_length) > LCMP_BITS'(MAX_WINDOW))
        begin
            len_eff = WIN_BITS'(MAX_WINDOW);
        end
        else
        begin
            len_eff = WIN_BITS'(cfg.window_length);
        end
        if (NCMP_BITS'(len_eff) < NCMP_BITS'(bx_number))
        begin
            n_in = len_eff;
        end
        else
        begin
            n_in = WIN_BITS'(bx_number);
        end
    end

    // Shift history on each transfer, clear behind the first crossing of an orbit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                count_hist_reg[i] <= '0;
                wheel_hist_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            count_hist_reg[0] <= stub_count;
            wheel_hist_reg[0] <= (stub_count != '0) ? wheel_mask : '0;
            for (int i = 1; i < MAX_WINDOW; i++)
            begin
                count_hist_reg[i] <= orbit_start ? '0 : count_hist_reg[i-1];
                wheel_hist_reg[i] <= orbit_start ? '0 : wheel_hist_reg[i-1];
            end
        end
    end

    // Sum the window in groups and look for close wheels
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            gsum_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if ((g * GROUP_SIZE + k < MAX_WINDOW)
                    && (g * GROUP_SIZE + k < int'(s1_n_reg)))
                begin
                    gsum_next[g] = gsum_next[g]
                                 + GSUM_BITS'(count_hist_reg[g * GROUP_SIZE + k]);
                end
            end
        end
        close_next = 1'b0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            for (int j = i + 1; j < MAX_WINDOW; j++)
            begin
                if (j < int'(s1_n_reg))
                begin
                    close_next = close_next
                               | wheels_close(wheel_hist_reg[i], wheel_hist_reg[j]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_clear_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_clear_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && (stub_count != '0) && (n_in != '0);
            s1_clear_reg <= accept && orbit_start;
            s2_valid_reg <= s1_valid_reg;
            s2_clear_reg <= s1_clear_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_bx_reg    <= bx_number;
        s1_n_reg     <= n_in;
        s2_bx_reg    <= s1_bx_reg;
        s2_n_reg     <= s1_n_reg;
        s2_close_reg <= close_next;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            s2_gsum_reg[g] <= gsum_next[g];
        end
    end

    // Decide on the window and drop crossings already emitted
    always_comb
    begin
        sum = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            sum = sum + SUM_BITS'(s2_gsum_reg[g]);
        end
        pass = (CMP_BITS'(sum) >= CMP_BITS'(cfg.min_stubs))
            && (!cfg.mode || s2_close_reg);
        any_eff = any_emitted_reg && !s2_clear_reg;
        lo      = s2_bx_reg - BX_BITS'(s2_n_reg) + BX_BITS'(1);
        push    = s2_valid_reg && pass && !(any_eff && (highest_reg >= s2_bx_reg));
        push_job.last_bx  = s2_bx_reg;
        push_job.first_bx = (any_eff && (highest_reg >= lo))
                          ? highest_reg + BX_BITS'(1) : lo;
        highest_next     = s2_clear_reg ? '0 : highest_reg;
        any_emitted_next = any_eff;
        if (push)
        begin
            highest_next     = s2_bx_reg;
            any_emitted_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            highest_reg     <= '0;
            any_emitted_reg <= 1'b0;
        end
        else
        begin
            highest_reg     <= highest_next;
            any_emitted_reg <= any_emitted_next;
        end
    end

    a_push_marks_emitted: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (any_emitted_reg && (highest_reg == $past(s2_bx_reg))))
        else $error("emission record not updated after job");

    a_job_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_job.first_bx <= push_job.last_bx))
        else $error("job with first crossing after last");

endmodule

// ===== rtl/sbx_back.sv =====
module sbx_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sbx_pkg::job_t                     head,
    input  logic [sbx_pkg::Q_CNT_BITS-1:0]    q_count,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sbx_pkg::BX_BITS-1:0]       selected_bx,
    output logic                              last
);
    import sbx_pkg::*;

    logic               cur_valid_reg;
    logic               cur_valid_next;
    logic [BX_BITS-1:0] cursor_reg;
    logic [BX_BITS-1:0] cursor_next;
    logic [BX_BITS-1:0] end_reg;
    logic [BX_BITS-1:0] end_next;
    logic               at_end;
    logic               xfer;

    assign at_end = (cursor_reg == end_reg);
    assign xfer   = cur_valid_reg && out_ready;

    // Load the next job when idle or when the current run finishes
    always_comb
    begin
        pop            = (q_count != '0) && (!cur_valid_reg || (xfer && at_end));
        cur_valid_next = cur_valid_reg;
        cursor_next    = cursor_reg;
        end_next       = end_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            cursor_next    = head.first_bx;
            end_next       = head.last_bx;
        end
        else if (xfer && at_end)
        begin
            cur_valid_next = 1'b0;
        end
        else if (xfer)
        begin
            cursor_next = cursor_reg + BX_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg <= cursor_next;
        end_reg    <= end_next;
    end

    assign out_valid   = cur_valid_reg;
    assign selected_bx = cursor_reg;
    assign last        = at_end;

    a_cursor_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cursor_reg <= end_reg))
        else $error("output cursor beyond end of run");

endmodule

// ===== rtl/stub_window_bx_selector.sv =====
// Path: a selected crossing passes the history and first-stage registers, the decision
// stage registers, the job queue and the output cursor before it reaches the output.
// Throughput: one item per cycle while in_ready is high; the back end emits one result per
// cycle while out_ready is high; a four-entry job queue and a two-stage evaluation pipeline
// absorb the difference while the back end emits all crossings that one item selects.
// Reset: asynchronous, active low; clears history, emission record, queue and sets
// window_length 1, min_stubs 0, mode 0. No clearing pass is needed.
module stub_window_bx_selector (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [sbx_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [sbx_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 orbit_start,
    input  logic [sbx_pkg::BX_BITS-1:0]          bx_number,
    input  logic [sbx_pkg::COUNT_BITS-1:0]       stub_count,
    input  logic [sbx_pkg::WHEEL_BITS-1:0]       wheel_mask,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sbx_pkg::BX_BITS-1:0]          selected_bx,
    output logic                                 last
);
    import sbx_pkg::*;

    cfg_t                  cfg_reg;
    cfg_t                  cfg_next;
    logic                  push;
    job_t                  push_job;
    logic                  pop;
    job_t                  head;
    logic [Q_CNT_BITS-1:0] q_count;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_WINDOW_LENGTH: cfg_next.window_length = cfg_data[LEN_BITS-1:0];
                CFG_MIN_STUBS:     cfg_next.min_stubs     = cfg_data[MIN_BITS-1:0];
                CFG_MODE:          cfg_next.mode          = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length <= LEN_BITS'(1);
            cfg_reg.min_stubs     <= '0;
            cfg_reg.mode          <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sbx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .orbit_start (orbit_start),
        .bx_number   (bx_number),
        .stub_count  (stub_count),
        .wheel_mask  (wheel_mask),
        .q_count     (q_count),
        .push        (push),
        .push_job    (push_job)
    );

    sbx_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .count    (q_count)
    );

    sbx_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_count     (q_count),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .selected_bx (selected_bx),
        .last        (last)
    );

endmodule
